// ===== rtl/nrsh_pkg.sv =====
package nrsh_pkg;

  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 8;
  localparam int HIT_W     = COORD_W + FRAC_BITS;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * COORD_W + 2;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int RATIO_W   = 2 * COORD_W;
  localparam int QB        = HIT_W;
  localparam int NUM_W     = RATIO_W + QB;
  localparam int MAG_W     = HIT_W + 1;
  localparam int DIST_W    = 2 * MAG_W + 1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_SEG   = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [HIT_W-1:0]   prior_x;
    logic signed [HIT_W-1:0]   prior_y;
    logic signed [COORD_W-1:0] seg_ax;
    logic signed [COORD_W-1:0] seg_ay;
    logic signed [COORD_W-1:0] seg_bx;
    logic signed [COORD_W-1:0] seg_by;
    logic                      last;
  } in_word_t;

  typedef struct packed {
    logic                      found;
    logic signed [HIT_W-1:0]   hit_x;
    logic signed [HIT_W-1:0]   hit_y;
    logic signed [COORD_W-1:0] hit_ax;
    logic signed [COORD_W-1:0] hit_ay;
    logic signed [COORD_W-1:0] hit_bx;
    logic signed [COORD_W-1:0] hit_by;
  } out_word_t;

  // classified word passed from front to back
  typedef struct packed {
    logic                      is_start;
    logic                      last;
    logic                      hit;
    logic                      colin;
    logic [RATIO_W-1:0]        ratio_n;
    logic [RATIO_W-1:0]        ratio_d;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] org_x;
    logic signed [COORD_W-1:0] org_y;
    logic signed [HIT_W-1:0]   prior_x;
    logic signed [HIT_W-1:0]   prior_y;
  } qword_t;

endpackage

// ===== rtl/nrsh_front.sv =====
module nrsh_front import nrsh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_word_t in_data,
  output logic     q_push,
  input  logic     q_full,
  output qword_t   q_data
);

  logic signed [COORD_W-1:0] ray_ox_r, ray_oy_r, ray_rx_r, ray_ry_r;

  logic                      s1_vld_r;
  logic                      s1_start_r, s1_last_r, s1_zero_r;
  logic signed [PROD_W-1:0]  p_ln_a_r, p_ln_b_r, p_ld_a_r, p_ld_b_r;
  logic signed [PROD_W-1:0]  p_nm_a_r, p_nm_b_r, p_dt_a_r, p_dt_b_r;
  logic signed [COORD_W-1:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r;
  logic signed [COORD_W-1:0] s1_ox_r, s1_oy_r;
  logic signed [HIT_W-1:0]   s1_px_r, s1_py_r;

  logic                      acc, s1_take;
  logic signed [DIFF_W-1:0]  ux, uy, vx, vy, wx, wy;
  logic signed [CROSS_W-1:0] ln, ld, nm, dt, lnf, ldf, nmf;
  logic                      hit;

  assign s1_take = !s1_vld_r || !q_full;
  assign full    = !s1_take;
  assign acc     = push && s1_take;
  assign q_push  = s1_vld_r && !q_full;

  // segment vectors relative to the current ray
  assign ux = DIFF_W'(in_data.seg_ax) - DIFF_W'(ray_ox_r);
  assign uy = DIFF_W'(in_data.seg_ay) - DIFF_W'(ray_oy_r);
  assign vx = DIFF_W'(in_data.seg_bx) - DIFF_W'(ray_ox_r);
  assign vy = DIFF_W'(in_data.seg_by) - DIFF_W'(ray_oy_r);
  assign wx = DIFF_W'(in_data.seg_bx) - DIFF_W'(in_data.seg_ax);
  assign wy = DIFF_W'(in_data.seg_by) - DIFF_W'(in_data.seg_ay);

  // stage 1: ray registers and cross-product terms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      ray_ox_r <= '0;
      ray_oy_r <= '0;
      ray_rx_r <= '0;
      ray_ry_r <= '0;
    end else begin
      if (s1_take) s1_vld_r <= acc;
      if (acc && in_data.cmd == CMD_START) begin
        ray_ox_r <= in_data.origin_x;
        ray_oy_r <= in_data.origin_y;
        ray_rx_r <= in_data.dir_x;
        ray_ry_r <= in_data.dir_y;
      end
    end
    if (acc) begin
      s1_start_r <= (in_data.cmd == CMD_START);
      s1_last_r  <= in_data.last;
      s1_zero_r  <= (ray_rx_r == '0) && (ray_ry_r == '0);
      p_ln_a_r   <= PROD_W'(ray_rx_r) * PROD_W'(uy);
      p_ln_b_r   <= PROD_W'(ray_ry_r) * PROD_W'(ux);
      p_ld_a_r   <= PROD_W'(ray_ry_r) * PROD_W'(wx);
      p_ld_b_r   <= PROD_W'(ray_rx_r) * PROD_W'(wy);
      p_nm_a_r   <= PROD_W'(uy) * PROD_W'(vx);
      p_nm_b_r   <= PROD_W'(ux) * PROD_W'(vy);
      p_dt_a_r   <= PROD_W'(ray_rx_r) * PROD_W'(ux);
      p_dt_b_r   <= PROD_W'(ray_ry_r) * PROD_W'(uy);
      s1_ax_r    <= in_data.seg_ax;
      s1_ay_r    <= in_data.seg_ay;
      s1_bx_r    <= in_data.seg_bx;
      s1_by_r    <= in_data.seg_by;
      s1_ox_r    <= in_data.origin_x;
      s1_oy_r    <= in_data.origin_y;
      s1_px_r    <= in_data.prior_x;
      s1_py_r    <= in_data.prior_y;
    end
  end

  // stage 2: hit classification with the sign of ld folded in
  always_comb begin
    ln  = CROSS_W'(p_ln_a_r) - CROSS_W'(p_ln_b_r);
    ld  = CROSS_W'(p_ld_a_r) - CROSS_W'(p_ld_b_r);
    nm  = CROSS_W'(p_nm_a_r) - CROSS_W'(p_nm_b_r);
    dt  = CROSS_W'(p_dt_a_r) + CROSS_W'(p_dt_b_r);
    lnf = (ld < 0) ? -ln : ln;
    ldf = (ld < 0) ? -ld : ld;
    nmf = (ld < 0) ? -nm : nm;
    if (ld == '0) begin
      hit = !s1_zero_r && (ln == '0) && (dt > 0);
    end else begin
      hit = !s1_zero_r && (lnf >= 0) && (lnf <= ldf) && (nmf > 0);
    end
    q_data.is_start = s1_start_r;
    q_data.last     = s1_last_r;
    q_data.hit      = hit;
    q_data.colin    = (ld == '0);
    q_data.ratio_n  = lnf[RATIO_W-1:0];
    q_data.ratio_d  = ldf[RATIO_W-1:0];
    q_data.ax       = s1_ax_r;
    q_data.ay       = s1_ay_r;
    q_data.bx       = s1_bx_r;
    q_data.by       = s1_by_r;
    q_data.org_x    = s1_ox_r;
    q_data.org_y    = s1_oy_r;
    q_data.prior_x  = s1_px_r;
    q_data.prior_y  = s1_py_r;
  end

endmodule

// ===== rtl/nrsh_fifo.sv =====
module nrsh_fifo import nrsh_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  qword_t wr_data,
  output logic   q_full,
  input  logic   rd_en,
  output qword_t rd_data,
  output logic   q_empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qword_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_data;
  end

  // pointers wrap at the depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/nrsh_back.sv =====
module nrsh_back import nrsh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  qword_t    q_data,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_DIST = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam int CNT_W = $clog2(QB + 1);

  logic [2:0]                state_r;
  qword_t                    cur_r;
  logic signed [COORD_W-1:0] org_x_r, org_y_r;
  logic [DIST_W-1:0]         best_dist_r, sq_r;
  logic                      inf_r, found_r, sel_r;
  logic signed [HIT_W-1:0]   best_hx_r, best_hy_r, hx_r, hy_r;
  logic signed [COORD_W-1:0] best_ax_r, best_ay_r, best_bx_r, best_by_r;
  logic [QB-1:0]             num_lo_r, quo_r;
  logic [RATIO_W-1:0]        rem_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      out_vld_r;
  out_word_t                 out_r;

  logic signed [DIFF_W-1:0]  wx, wy, w_sel;
  logic [COORD_W-1:0]        w_mag;
  logic [NUM_W-1:0]          numer;
  logic [RATIO_W:0]          r2;
  logic                      ge, rnd_up;
  logic [QB:0]               q_rnd;
  logic signed [HIT_W-1:0]   base, hit_c;
  logic signed [MAG_W-1:0]   dx, dy;
  logic [MAG_W-1:0]          mx, my;
  logic                      out_free;
  logic                      emit_fire;

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign empty     = !out_vld_r;
  assign out_data  = out_r;
  assign out_free  = !out_vld_r || pop;
  assign emit_fire = (state_r == S_EMIT) && out_free;

  // shared lerp datapath, one coordinate at a time
  always_comb begin
    wx     = DIFF_W'(cur_r.bx) - DIFF_W'(cur_r.ax);
    wy     = DIFF_W'(cur_r.by) - DIFF_W'(cur_r.ay);
    w_sel  = sel_r ? wy : wx;
    w_mag  = (w_sel < 0) ? COORD_W'(-w_sel) : COORD_W'(w_sel);
    numer  = NUM_W'(cur_r.ratio_n * w_mag) << FRAC_BITS;
    r2     = {rem_r, num_lo_r[QB-1]};
    ge     = (r2 >= {1'b0, cur_r.ratio_d});
    rnd_up = ({rem_r, 1'b0} >= {1'b0, cur_r.ratio_d});
    q_rnd  = {1'b0, quo_r} + (QB+1)'(rnd_up);
    base   = sel_r ? (HIT_W'(cur_r.ay) <<< FRAC_BITS) : (HIT_W'(cur_r.ax) <<< FRAC_BITS);
    hit_c  = (w_sel < 0) ? base - HIT_W'(q_rnd) : base + HIT_W'(q_rnd);
    dx     = MAG_W'(hx_r) - (MAG_W'(org_x_r) <<< FRAC_BITS);
    dy     = MAG_W'(hy_r) - (MAG_W'(org_y_r) <<< FRAC_BITS);
    mx     = (dx < 0) ? MAG_W'(-dx) : MAG_W'(dx);
    my     = (dy < 0) ? MAG_W'(-dy) : MAG_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      org_x_r     <= '0;
      org_y_r     <= '0;
      best_dist_r <= '0;
      inf_r       <= 1'b1;
      found_r     <= 1'b0;
      best_hx_r   <= '0;
      best_hy_r   <= '0;
      best_ax_r   <= '0;
      best_ay_r   <= '0;
      best_bx_r   <= '0;
      best_by_r   <= '0;
      sel_r       <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      out_vld_r <= emit_fire || (out_vld_r && !pop);
      case (state_r)
        // take one word and route it
        S_IDLE: begin
          if (!q_empty) begin
            cur_r <= q_data;
            sel_r <= 1'b0;
            if (q_data.is_start == 1'b1) begin
              org_x_r   <= q_data.org_x;
              org_y_r   <= q_data.org_y;
              hx_r      <= q_data.prior_x;
              hy_r      <= q_data.prior_y;
              inf_r     <= (q_data.prior_x == (HIT_W'(q_data.org_x) <<< FRAC_BITS)) &&
                           (q_data.prior_y == (HIT_W'(q_data.org_y) <<< FRAC_BITS));
              found_r   <= 1'b0;
              best_hx_r <= '0;
              best_hy_r <= '0;
              best_ax_r <= '0;
              best_ay_r <= '0;
              best_bx_r <= '0;
              best_by_r <= '0;
              state_r   <= S_DIST;
            end else if (q_data.hit && q_data.colin) begin
              hx_r    <= HIT_W'(q_data.ax) <<< FRAC_BITS;
              hy_r    <= HIT_W'(q_data.ay) <<< FRAC_BITS;
              state_r <= S_DIST;
            end else if (q_data.hit) begin
              state_r <= S_MUL;
            end else begin
              state_r <= q_data.last ? S_EMIT : S_IDLE;
            end
          end
        end
        // numerator ln*|w|*2^F, top part seeds the remainder
        S_MUL: begin
          rem_r    <= numer[NUM_W-1:QB];
          num_lo_r <= numer[QB-1:0];
          quo_r    <= '0;
          cnt_r    <= CNT_W'(QB);
          state_r  <= S_DIV;
        end
        // restoring division, one quotient bit a cycle
        S_DIV: begin
          rem_r    <= ge ? RATIO_W'(r2 - {1'b0, cur_r.ratio_d}) : RATIO_W'(r2);
          num_lo_r <= num_lo_r << 1;
          quo_r    <= {quo_r[QB-2:0], ge};
          cnt_r    <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) state_r <= S_RND;
        end
        // round half away from zero and place on the segment
        S_RND: begin
          if (sel_r) begin
            hy_r    <= hit_c;
            state_r <= S_DIST;
          end else begin
            hx_r    <= hit_c;
            sel_r   <= 1'b1;
            state_r <= S_MUL;
          end
        end
        S_DIST: begin
          sq_r    <= DIST_W'(mx * mx) + DIST_W'(my * my);
          state_r <= S_CMP;
        end
        // keep the strictly nearer hit
        S_CMP: begin
          if (cur_r.is_start) begin
            best_dist_r <= sq_r;
          end else if (inf_r || sq_r < best_dist_r) begin
            best_dist_r <= sq_r;
            inf_r       <= 1'b0;
            found_r     <= 1'b1;
            best_hx_r   <= hx_r;
            best_hy_r   <= hy_r;
            best_ax_r   <= cur_r.ax;
            best_ay_r   <= cur_r.ay;
            best_bx_r   <= cur_r.bx;
            best_by_r   <= cur_r.by;
          end
          state_r <= cur_r.last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (emit_fire) begin
      out_r.found  <= found_r;
      out_r.hit_x  <= found_r ? best_hx_r : '0;
      out_r.hit_y  <= found_r ? best_hy_r : '0;
      out_r.hit_ax <= found_r ? best_ax_r : '0;
      out_r.hit_ay <= found_r ? best_ay_r : '0;
      out_r.hit_bx <= found_r ? best_bx_r : '0;
      out_r.hit_by <= found_r ? best_by_r : '0;
    end
  end

endmodule

// ===== rtl/nearest_ray_segment_hit_core.sv =====
// Nearest ray-segment hit. A start word (cmd 0) loads the ray origin, direction
// and an optional prior hit (equal to the origin scaled by 2^8 means none);
// segment words (cmd 1) follow, and a word with last set returns found, the
// nearest hit in Q.8 and its segment. The front takes one word per cycle while
// the queue is not full and computes the cross products; a short queue
// decouples it from the back end, which takes a word only when idle. A missed
// segment ends there, a start or collinear hit passes the distance and compare
// states; a proper hit first runs the shared bit-serial divider per coordinate.
module nearest_ray_segment_hit_core import nrsh_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_data
);

  qword_t fq_wdata, fq_rdata;
  logic   fq_push, fq_full, fq_pop, fq_empty;

  nrsh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_push  (fq_push),
    .q_full  (fq_full),
    .q_data  (fq_wdata)
  );

  nrsh_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_data (fq_wdata),
    .q_full  (fq_full),
    .rd_en   (fq_pop),
    .rd_data (fq_rdata),
    .q_empty (fq_empty)
  );

  nrsh_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (fq_rdata),
    .q_empty  (fq_empty),
    .q_pop    (fq_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
